@@ design/ldp_pkg.sv @@
// ----------------------------------------------------------------------------
// ldp_pkg
// shared types and constants for the legendre polynomial evaluator
// ----------------------------------------------------------------------------
`default_nettype none

package ldp_pkg;

	// order register
	localparam int unsigned ORDER_W = 5;
	localparam logic [ORDER_W-1:0] ORDER_RESET = 5'd4;

	// quotient bits resolved by the divider in one cycle
	localparam int unsigned DIV_BITS_PER_CYCLE = 4;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load;       // capture point and seed the recurrence
		logic mul_deriv;  // multiplier operand: 1 = d1, 0 = p1
		logic acc_poly;   // form polynomial numerator
		logic acc_deriv;  // form derivative numerator
		logic div_start;  // launch both dividers
		logic update;     // shift in the new recurrence terms
		logic out_load;   // capture result word
	} ldp_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic div_done;
	} ldp_sts_t;

endpackage

`default_nettype wire

@@ design/ldp_div.sv @@
// ----------------------------------------------------------------------------
// ldp_div
// unsigned long divider by a small divisor, several quotient bits per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module ldp_div
	import ldp_pkg::*;
#(
	parameter int unsigned WIDTH = 29,
	parameter int unsigned DVW   = 5
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [WIDTH-1:0] dividend,
	input  wire logic [DVW-1:0]   divisor,
	output logic      [WIDTH-1:0] quotient,
	output logic                  done
);

	localparam int unsigned STEPS = (WIDTH + DIV_BITS_PER_CYCLE - 1) / DIV_BITS_PER_CYCLE;
	localparam int unsigned PW    = STEPS * DIV_BITS_PER_CYCLE;
	localparam int unsigned CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

	logic [PW-1:0]    work_q;
	logic [DVW-1:0]   rem_q;
	logic [DVW-1:0]   dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [PW-1:0]    work_nxt;
	logic [DVW-1:0]   rem_nxt;
	logic             last;

	// restoring division, msb first; quotient bits shift in at the bottom
	always_comb begin
		logic [PW-1:0] w;
		logic [DVW:0]  t;
		logic [DVW-1:0] r;
		w = work_q;
		r = rem_q;
		for (int k = 0; k < DIV_BITS_PER_CYCLE; k++) begin
			t = {r, w[PW-1]};
			w = {w[PW-2:0], 1'b0};
			if (t >= {1'b0, dvs_q}) begin
				t = t - {1'b0, dvs_q};
				w[0] = 1'b1;
			end
			r = t[DVW-1:0];
		end
		work_nxt = w;
		rem_nxt  = r;
	end

	assign last = (cnt_q == CNT_W'(STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && last;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= PW'(dividend);
			rem_q  <= '0;
			dvs_q  <= divisor;
		end else if (busy_q) begin
			work_q <= work_nxt;
			rem_q  <= rem_nxt;
		end
	end

	assign quotient = work_q[WIDTH-1:0];
	assign done     = done_q;

endmodule

`default_nettype wire

@@ design/ldp_dpath.sv @@
// ----------------------------------------------------------------------------
// ldp_dpath
// recurrence registers, shared multiplier, numerator accumulation, dividers
// ----------------------------------------------------------------------------
`default_nettype none

module ldp_dpath
	import ldp_pkg::*;
#(
	parameter int unsigned MAX_ORDER = 16,
	parameter int unsigned FRAC_BITS = 16,
	localparam int unsigned XW   = FRAC_BITS + 2,
	localparam int unsigned DMAX = MAX_ORDER * (MAX_ORDER + 1) / 2,
	localparam int unsigned DW   = $clog2(DMAX + 1) + FRAC_BITS + 1,
	localparam int unsigned IW   = $clog2(MAX_ORDER + 1)
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire ldp_cmd_t             cmd,
	input  wire logic        [IW-1:0] step_idx,
	output ldp_sts_t                  sts,
	input  wire logic signed [XW-1:0] point,
	output logic signed      [XW-1:0] poly_value,
	output logic signed      [DW-1:0] deriv_value
);

	localparam int unsigned CW  = IW + 1;
	localparam int unsigned NW  = 2 * FRAC_BITS + $clog2(3 * MAX_ORDER * (DMAX + 1)) + 1;
	localparam int unsigned QW  = NW - 1 - FRAC_BITS;
	localparam int unsigned PRW = XW + DW;

	localparam logic signed [XW-1:0] ONE_X = XW'(1) << FRAC_BITS;
	localparam logic [QW-1:0] PLIM = QW'(1) << FRAC_BITS;
	localparam logic [QW-1:0] DLIM = QW'(DMAX) << FRAC_BITS;

	logic signed [XW-1:0]  x_q, p0_q, p1_q;
	logic signed [DW-1:0]  d0_q, d1_q;
	logic signed [PRW-1:0] prod_q;
	logic signed [NW-1:0]  num_p_q, num_d_q;
	logic                  neg_p_q, neg_d_q;
	logic signed [XW-1:0]  poly_q;
	logic signed [DW-1:0]  deriv_q;

	logic signed [XW-1:0]  x_clamp;
	logic signed [DW-1:0]  mul_opnd;
	logic signed [NW-1:0]  prod_x;
	logic        [CW-1:0]  c1, c0;
	logic signed [CW:0]    c1_s, c0_s;
	logic        [NW-1:0]  mag_p, mag_d;
	logic        [QW-1:0]  q_p, q_d, qm_p, qm_d;
	logic signed [XW-1:0]  pv, p_new;
	logic signed [DW-1:0]  dv, d_new;
	logic                  done_p, done_d;

	// saturate x to [-1, 1]
	always_comb begin
		priority if (point > ONE_X) begin
			x_clamp = ONE_X;
		end else if (point < -ONE_X) begin
			x_clamp = -ONE_X;
		end else begin
			x_clamp = point;
		end
	end

	assign mul_opnd = cmd.mul_deriv ? d1_q : DW'(p1_q);
	assign prod_x   = NW'(prod_q);

	// coefficients 2i-1 and i-1
	assign c1   = {step_idx, 1'b0} - CW'(1);
	assign c0   = CW'(step_idx) - CW'(1);
	assign c1_s = $signed({1'b0, c1});
	assign c0_s = $signed({1'b0, c0});

	// magnitudes with the fraction scale dropped; floor of floor keeps truncation
	assign mag_p = num_p_q[NW-1] ? NW'(-num_p_q) : NW'(num_p_q);
	assign mag_d = num_d_q[NW-1] ? NW'(-num_d_q) : NW'(num_d_q);

	ldp_div #(
		.WIDTH (QW),
		.DVW   (IW)
	) u_div_p (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (mag_p[NW-2:FRAC_BITS]),
		.divisor  (step_idx),
		.quotient (q_p),
		.done     (done_p)
	);

	ldp_div #(
		.WIDTH (QW),
		.DVW   (IW)
	) u_div_d (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (mag_d[NW-2:FRAC_BITS]),
		.divisor  (step_idx),
		.quotient (q_d),
		.done     (done_d)
	);

	// both lanes run in lockstep
	assign sts.div_done = done_p & done_d;

	// saturate to the function bounds and restore the sign
	assign qm_p  = (q_p > PLIM) ? PLIM : q_p;
	assign qm_d  = (q_d > DLIM) ? DLIM : q_d;
	assign pv    = XW'(qm_p);
	assign dv    = DW'(qm_d);
	assign p_new = neg_p_q ? -pv : pv;
	assign d_new = neg_d_q ? -dv : dv;

	always_ff @(posedge clk) begin
		prod_q <= x_q * mul_opnd;
		if (cmd.load) begin
			x_q  <= x_clamp;
			p0_q <= ONE_X;
			p1_q <= x_clamp;
			d0_q <= '0;
			d1_q <= DW'(ONE_X);
		end else if (cmd.update) begin
			p0_q <= p1_q;
			p1_q <= p_new;
			d0_q <= d1_q;
			d1_q <= d_new;
		end
		if (cmd.acc_poly) begin
			num_p_q <= c1_s * prod_x - c0_s * (NW'(p0_q) <<< FRAC_BITS);
		end
		if (cmd.acc_deriv) begin
			num_d_q <= c1_s * ((NW'(p1_q) <<< FRAC_BITS) + prod_x)
				- c0_s * (NW'(d0_q) <<< FRAC_BITS);
		end
		if (cmd.div_start) begin
			neg_p_q <= num_p_q[NW-1];
			neg_d_q <= num_d_q[NW-1];
		end
		if (cmd.out_load) begin
			poly_q  <= p1_q;
			deriv_q <= d1_q;
		end
	end

	assign poly_value  = poly_q;
	assign deriv_value = deriv_q;

endmodule

`default_nettype wire

@@ design/ldp_ctrl.sv @@
// ----------------------------------------------------------------------------
// ldp_ctrl
// sequencer for the recurrence steps, order register and handshakes
// ----------------------------------------------------------------------------
`default_nettype none

module ldp_ctrl
	import ldp_pkg::*;
#(
	parameter int unsigned MAX_ORDER = 16,
	localparam int unsigned IW = $clog2(MAX_ORDER + 1)
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [ORDER_W-1:0] cfg_wdata,
	input  wire logic               in_valid,
	output logic                    in_stall,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output ldp_cmd_t                cmd,
	output logic         [IW-1:0]   step_idx,
	input  wire ldp_sts_t           sts
);

	localparam int unsigned CMP_W = (IW > ORDER_W) ? IW : ORDER_W;

	typedef enum logic [6:0] {
		S_IDLE     = 7'b0000001,
		S_MUL_P    = 7'b0000010,
		S_MUL_D    = 7'b0000100,
		S_ACC_D    = 7'b0001000,
		S_DIV_GO   = 7'b0010000,
		S_DIV_WAIT = 7'b0100000,
		S_FINISH   = 7'b1000000
	} state_t;

	state_t             state_q, state_nxt;
	logic [ORDER_W-1:0] order_q;
	logic [IW-1:0]      idx_q;
	logic [IW-1:0]      n_eff;
	logic               out_valid_q;
	logic               in_acc;
	logic               out_free;

	always_comb begin
		priority if (order_q == '0) begin
			n_eff = IW'(1);
		end else if (CMP_W'(order_q) > CMP_W'(MAX_ORDER)) begin
			n_eff = IW'(MAX_ORDER);
		end else begin
			n_eff = IW'(order_q);
		end
	end

	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					cmd.load  = 1'b1;
					state_nxt = (n_eff == IW'(1)) ? S_FINISH : S_MUL_P;
				end
			end
			S_MUL_P: begin
				state_nxt = S_MUL_D;
			end
			S_MUL_D: begin
				cmd.acc_poly  = 1'b1;
				cmd.mul_deriv = 1'b1;
				state_nxt     = S_ACC_D;
			end
			S_ACC_D: begin
				cmd.acc_deriv = 1'b1;
				state_nxt     = S_DIV_GO;
			end
			S_DIV_GO: begin
				cmd.div_start = 1'b1;
				state_nxt     = S_DIV_WAIT;
			end
			S_DIV_WAIT: begin
				if (sts.div_done) begin
					cmd.update = 1'b1;
					state_nxt  = (idx_q == n_eff) ? S_FINISH : S_MUL_P;
				end
			end
			S_FINISH: begin
				// hold until the output word slot frees up
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			order_q     <= ORDER_RESET;
			idx_q       <= IW'(2);
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_we) begin
				order_q <= cfg_wdata;
			end
			if (cmd.load) begin
				idx_q <= IW'(2);
			end else if (cmd.update) begin
				idx_q <= idx_q + IW'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign step_idx  = idx_q;

endmodule

`default_nettype wire

@@ design/legendre_poly_and_derivative_top.sv @@
// ----------------------------------------------------------------------------
// legendre_poly_and_derivative_top
// returns P_n(x) and P_n'(x) by the three-term recurrence, n from a register
// ----------------------------------------------------------------------------
// input channel carries one word: point x, signed, FRAC_BITS fraction bits,
//   saturated to [-1, 1]. output channel carries poly_value and deriv_value.
// both channels: a word moves on a clock edge with valid high and stall low.
// cfg_we writes cfg_wdata into the order register (reset value 4); order 0
//   acts as 1 and orders above MAX_ORDER act as MAX_ORDER. write only when idle.
// each recurrence index steps through S_MUL_P, S_MUL_D, S_ACC_D, S_DIV_GO and
//   S_DIV_WAIT: two passes through the shared multiplier, one accumulate, one
//   divider launch, and the long division by i at four bits per cycle, whose
//   dividend is the QW-bit numerator magnitude.
// one point is in flight at a time; in_stall is low only while idle.
// the finished word sits in an output register, so the next point is taken
//   while it waits; a stalled receiver holds the word and, once another
//   result is done, holds the block in its final state.
// reset clears the sequencer and output valid and reloads order with 4.
// ----------------------------------------------------------------------------
`default_nettype none

module legendre_poly_and_derivative_top
	import ldp_pkg::*;
#(
	parameter int unsigned MAX_ORDER = 16,
	parameter int unsigned FRAC_BITS = 16,
	localparam int unsigned XW   = FRAC_BITS + 2,
	localparam int unsigned DMAX = MAX_ORDER * (MAX_ORDER + 1) / 2,
	localparam int unsigned DW   = $clog2(DMAX + 1) + FRAC_BITS + 1
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic        [ORDER_W-1:0] cfg_wdata,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic signed [XW-1:0]      point,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic signed      [XW-1:0]      poly_value,
	output logic signed      [DW-1:0]      deriv_value
);

	localparam int unsigned IW = $clog2(MAX_ORDER + 1);

	ldp_cmd_t      cmd;
	ldp_sts_t      sts;
	logic [IW-1:0] step_idx;

	ldp_ctrl #(
		.MAX_ORDER (MAX_ORDER)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.step_idx  (step_idx),
		.sts       (sts)
	);

	ldp_dpath #(
		.MAX_ORDER (MAX_ORDER),
		.FRAC_BITS (FRAC_BITS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.step_idx    (step_idx),
		.sts         (sts),
		.point       (point),
		.poly_value  (poly_value),
		.deriv_value (deriv_value)
	);

endmodule

`default_nettype wire

@@ tb/legendre_poly_and_derivative_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// legendre_poly_and_derivative_top_tb
// self-checking bench for the legendre polynomial and derivative evaluator
// ----------------------------------------------------------------------------
// a directed table covers reset order, order extremes, endpoints and point
// saturation. Random phases follow, each with its own order and an idle pattern
// on no channel, the sender, the receiver or both. Every output word is compared
// with the bench's own fixed-point recurrence.
// ----------------------------------------------------------------------------

module legendre_poly_and_derivative_top_tb;
	import ldp_pkg::*;

	localparam int MAX_ORDER = 16;
	localparam int FRAC_BITS = 16;
	localparam int XW = FRAC_BITS + 2;
	localparam int DW = $clog2(MAX_ORDER * (MAX_ORDER + 1) / 2 + 1) + FRAC_BITS + 1;
	localparam longint ONE = longint'(1) << FRAC_BITS;
	localparam longint DERIV_LIM = longint'(MAX_ORDER * (MAX_ORDER + 1) / 2) << FRAC_BITS;
	localparam int FX1 = 65536;
	localparam int CYCLE_LIMIT = 1500000;
	localparam int DIRECTED_ROWS = 24;
	localparam int PHASES = 8;

	typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	typedef struct {
		logic signed [XW-1:0] poly;
		logic signed [DW-1:0] deriv;
	} legendre_word_t;

	typedef struct {
		logic [ORDER_W-1:0]   ord;
		logic signed [XW-1:0] pt;
		bit                   known;
		logic signed [XW-1:0] poly;
		logic signed [DW-1:0] deriv;
	} stim_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [ORDER_W-1:0]   cfg_wdata;
	logic                 in_valid;
	logic                 in_stall;
	logic signed [XW-1:0] point;
	logic                 out_valid;
	logic                 out_stall;
	logic signed [XW-1:0] poly_value;
	logic signed [DW-1:0] deriv_value;

	legendre_word_t     expected_evals[$];
	logic [ORDER_W-1:0] cur_order;
	idle_mode_t         idle_mode;
	int                 mismatches;
	int                 cycle_count;
	stim_row_t          dir_rows[DIRECTED_ROWS];
	logic [ORDER_W-1:0] phase_order[PHASES];
	int                 phase_items[PHASES];

	legendre_poly_and_derivative_top #(
		.MAX_ORDER(MAX_ORDER),
		.FRAC_BITS(FRAC_BITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.point(point),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.poly_value(poly_value),
		.deriv_value(deriv_value)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic longint clip(input longint v, input longint lim);
		if (v > lim)
			return lim;
		if (v < -lim)
			return -lim;
		return v;
	endfunction

	// three-term recurrence, each numerator exact, one truncation toward zero per step
	function automatic legendre_word_t legendre_eval(input logic [ORDER_W-1:0] ord,
			input logic signed [XW-1:0] pt);
		legendre_word_t r;
		longint x, p0, p1, d0, d1, pn, dn, num;
		int n, i;
		x = clip(longint'(pt), ONE);
		n = ord;
		if (n < 1)
			n = 1;
		if (n > MAX_ORDER)
			n = MAX_ORDER;
		p0 = ONE;
		p1 = x;
		d0 = 0;
		d1 = ONE;
		for (i = 2; i <= n; i++) begin
			num = longint'(2 * i - 1) * x * p1 - longint'(i - 1) * p0 * ONE;
			pn = clip(num / (longint'(i) * ONE), ONE);
			num = longint'(2 * i - 1) * p1 * ONE + longint'(2 * i - 1) * x * d1
				- longint'(i - 1) * d0 * ONE;
			dn = clip(num / (longint'(i) * ONE), DERIV_LIM);
			p0 = p1;
			p1 = pn;
			d0 = d1;
			d1 = dn;
		end
		r.poly = p1[XW-1:0];
		r.deriv = d1[DW-1:0];
		return r;
	endfunction

	// input side goes quiet until every outstanding word has come back
	task automatic drain();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (expected_evals.size() != 0);
	endtask

	task automatic write_order(input logic [ORDER_W-1:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_order = v;
	endtask

	task automatic send_point(input logic signed [XW-1:0] pt, input legendre_word_t want);
		int gap_pct;
		gap_pct = (idle_mode == IDLE_SENDER) ? 63 : (idle_mode == IDLE_BOTH) ? 25 : 0;
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		point <= pt;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		expected_evals.push_back(want);
	endtask

	function automatic logic signed [XW-1:0] random_point();
		int r;
		r = $urandom_range(99);
		if (r < 6)
			return (r < 2) ? XW'(FX1) : (r < 4) ? -XW'(FX1) : '0;
		if (r < 14)
			return XW'($urandom);
		return XW'(int'($urandom_range(2 * FX1)) - FX1);
	endfunction

	always @(posedge clk) begin
		case (idle_mode)
			IDLE_RECEIVER: out_stall <= ($urandom_range(99) < 63);
			IDLE_BOTH:     out_stall <= ($urandom_range(99) < 25);
			default:       out_stall <= 1'b0;
		endcase
	end

	always @(posedge clk) begin : check_results
		legendre_word_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_evals.size() == 0) begin
				$error("unexpected word: poly_value %0d deriv_value %0d", poly_value, deriv_value);
				mismatches++;
			end else begin
				want = expected_evals.pop_front();
				if (poly_value !== want.poly) begin
					$error("poly_value: expected %0d, actual %0d", want.poly, poly_value);
					mismatches++;
				end
				if (deriv_value !== want.deriv) begin
					$error("deriv_value: expected %0d, actual %0d", want.deriv, deriv_value);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("** legendre_poly_and_derivative_top: FAILED **");
			$finish;
		end
	end

	initial begin : stimulus
		legendre_word_t want;
		logic signed [XW-1:0] pt;
		idle_mode = IDLE_NONE;
		cur_order = ORDER_RESET;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		in_valid <= 1'b0;
		point <= '0;

		// endpoints give P = (+-1)^n and P' = (+-1)^(n+1) n(n+1)/2 exactly
		dir_rows = '{
			'{5'd4,  XW'(FX1),     1'b1, XW'(FX1),    DW'(10 * FX1)},
			'{5'd4,  -XW'(FX1),    1'b1, XW'(FX1),    -DW'(10 * FX1)},
			'{5'd4,  '0,           1'b0, '0,          '0},
			'{5'd4,  XW'(131071),  1'b1, XW'(FX1),    DW'(10 * FX1)},
			'{5'd4,  -XW'(131072), 1'b1, XW'(FX1),    -DW'(10 * FX1)},
			'{5'd1,  XW'(12345),   1'b1, XW'(12345),  DW'(FX1)},
			'{5'd1,  -XW'(FX1),    1'b1, -XW'(FX1),   DW'(FX1)},
			'{5'd1,  XW'(131071),  1'b1, XW'(FX1),    DW'(FX1)},
			'{5'd0,  -XW'(777),    1'b1, -XW'(777),   DW'(FX1)},
			'{5'd0,  XW'(65537),   1'b1, XW'(FX1),    DW'(FX1)},
			'{5'd16, XW'(FX1),     1'b1, XW'(FX1),    DW'(136 * FX1)},
			'{5'd16, -XW'(FX1),    1'b1, XW'(FX1),    -DW'(136 * FX1)},
			'{5'd16, '0,           1'b0, '0,          '0},
			'{5'd16, XW'(1),       1'b0, '0,          '0},
			'{5'd16, -XW'(1),      1'b0, '0,          '0},
			'{5'd16, XW'(65535),   1'b0, '0,          '0},
			'{5'd16, -XW'(65535),  1'b0, '0,          '0},
			'{5'd31, XW'(FX1),     1'b1, XW'(FX1),    DW'(136 * FX1)},
			'{5'd31, XW'(40000),   1'b0, '0,          '0},
			'{5'd17, -XW'(FX1),    1'b1, XW'(FX1),    -DW'(136 * FX1)},
			'{5'd2,  XW'(30000),   1'b0, '0,          '0},
			'{5'd2,  -XW'(131072), 1'b1, XW'(FX1),    -DW'(3 * FX1)},
			'{5'd3,  -XW'(FX1),    1'b1, -XW'(FX1),   DW'(6 * FX1)},
			'{5'd3,  XW'(98304),   1'b1, XW'(FX1),    DW'(6 * FX1)}
		};
		phase_order = '{5'd3, 5'd16, 5'd1, 5'd10, 5'd31, 5'd6, 5'd21, 5'd2};
		phase_items = '{90, 30, 90, 70, 30, 90, 30, 90};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// first rows run on the reset order
		foreach (dir_rows[k]) begin
			if (dir_rows[k].ord != cur_order)
				write_order(dir_rows[k].ord);
			if (dir_rows[k].known) begin
				want.poly = dir_rows[k].poly;
				want.deriv = dir_rows[k].deriv;
			end else begin
				want = legendre_eval(cur_order, dir_rows[k].pt);
			end
			send_point(dir_rows[k].pt, want);
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			write_order(phase_order[ph]);
			idle_mode = idle_mode_t'(ph % 4);
			for (int k = 0; k < phase_items[ph]; k++) begin
				if ($urandom_range(39) == 0)
					drain();
				pt = random_point();
				send_point(pt, legendre_eval(cur_order, pt));
			end
		end

		idle_mode = IDLE_NONE;
		drain();
		// catch any stray word after the last expected one
		repeat (250) @(posedge clk);
		if (mismatches == 0 && expected_evals.size() == 0)
			$display("** legendre_poly_and_derivative_top: PASSED **");
		else
			$display("** legendre_poly_and_derivative_top: FAILED **");
		$finish;
	end

endmodule
